@@ rtl/sfq_pkg.sv @@
package sfq_pkg;

    // Command codes on the request channel
    typedef enum logic [1:0] {
        CMD_EXCHANGE = 2'd0,
        CMD_APPEND   = 2'd1,
        CMD_COMMIT   = 2'd2,
        CMD_NOP      = 2'd3
    } cmd_t;

    // Receive framing states
    typedef enum logic [1:0] {
        RX_IDLE    = 2'd0,
        RX_LEN_HI  = 2'd1,
        RX_LEN_LO  = 2'd2,
        RX_PAYLOAD = 2'd3
    } rx_state_t;

    localparam logic [7:0] FRAME_START  = 8'hFF;
    localparam int         HEADER_BYTES = 3;

    // Per-request result, before the store read data is merged in
    typedef struct packed {
        logic       tx_from_mem;
        logic [7:0] tx_hdr;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       payload_last;
        logic       irq_n;
        logic       push_status;
    } step_res_t;

endpackage

@@ rtl/sfq_store_ram.sv @@
module sfq_store_ram
    import sfq_pkg::*;
#(
    parameter int DEPTH  = 632,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] store_mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/sfq_ctrl.sv @@
module sfq_ctrl
    import sfq_pkg::*;
#(
    parameter int SLOTS      = 8,
    parameter int SLOT_BYTES = 80,
    parameter int ADDR_W     = $clog2(SLOTS * (SLOT_BYTES - 1))
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [1:0]        cmd,
    input  logic [7:0]        data_byte,
    output logic              mem_wr_en,
    output logic [ADDR_W-1:0] mem_wr_addr,
    output logic [7:0]        mem_wr_data,
    output logic              mem_rd_en,
    output logic [ADDR_W-1:0] mem_rd_addr,
    output step_res_t         res
);

    localparam int PAYLOAD_MAX = SLOT_BYTES - 1;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int LEN_W       = $clog2(SLOT_BYTES);
    localparam int POS_W       = $clog2(SLOT_BYTES + 2);

    localparam logic [ADDR_W-1:0] BASE_STEP = ADDR_W'(PAYLOAD_MAX);
    localparam logic [ADDR_W-1:0] BASE_LAST = ADDR_W'((SLOTS - 1) * PAYLOAD_MAX);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(SLOTS);

    rx_state_t         rx_state_reg,  rx_state_next;
    logic [15:0]       rx_length_reg, rx_length_next;
    logic [15:0]       rx_count_reg,  rx_count_next;
    logic [SLOT_W-1:0] head_reg,      head_next;
    logic [SLOT_W-1:0] tail_reg,      tail_next;
    logic [ADDR_W-1:0] head_base_reg, head_base_next;
    logic [ADDR_W-1:0] tail_base_reg, tail_base_next;
    logic [CNT_W-1:0]  queued_reg,    queued_next;
    logic [POS_W-1:0]  tx_pos_reg,    tx_pos_next;
    logic [LEN_W-1:0]  build_len_reg, build_len_next;
    logic              build_drop_reg, build_drop_next;
    logic              attn_reg,      attn_next;

    logic [LEN_W-1:0]  slot_len_reg [SLOTS];
    logic              slot_wr_en;

    logic [LEN_W-1:0]  cur_len;
    logic [15:0]       cur_len16;
    logic [POS_W:0]    pos_inc;
    logic [POS_W:0]    len_end;
    logic [15:0]       rx_len_new;
    logic [15:0]       rx_count_inc;
    logic              queue_full;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_state_reg   <= RX_IDLE;
            rx_length_reg  <= '0;
            rx_count_reg   <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            head_base_reg  <= '0;
            tail_base_reg  <= '0;
            queued_reg     <= '0;
            tx_pos_reg     <= '0;
            build_len_reg  <= '0;
            build_drop_reg <= 1'b0;
            attn_reg       <= 1'b1;
        end
        else
        begin
            rx_state_reg   <= rx_state_next;
            rx_length_reg  <= rx_length_next;
            rx_count_reg   <= rx_count_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            head_base_reg  <= head_base_next;
            tail_base_reg  <= tail_base_next;
            queued_reg     <= queued_next;
            tx_pos_reg     <= tx_pos_next;
            build_len_reg  <= build_len_next;
            build_drop_reg <= build_drop_next;
            attn_reg       <= attn_next;
        end
    end

    // Committed slot lengths, written at tail, read at head
    always_ff @(posedge clk)
    begin
        if (slot_wr_en)
        begin
            slot_len_reg[tail_reg] <= build_len_reg;
        end
    end

    assign cur_len      = slot_len_reg[head_reg];
    assign cur_len16    = 16'(cur_len);
    assign pos_inc      = {1'b0, tx_pos_reg} + (POS_W + 1)'(1);
    assign len_end      = (POS_W + 1)'(cur_len) + (POS_W + 1)'(HEADER_BYTES);
    assign rx_len_new   = {rx_length_reg[15:8], data_byte};
    assign rx_count_inc = rx_count_reg + 16'd1;
    assign queue_full   = (queued_reg == CNT_FULL);

    assign mem_wr_addr = tail_base_reg + ADDR_W'(build_len_reg);
    assign mem_wr_data = data_byte;
    assign mem_rd_addr = head_base_reg + ADDR_W'(tx_pos_reg - POS_W'(HEADER_BYTES));

    // Command decode and next state
    always_comb
    begin
        rx_state_next   = rx_state_reg;
        rx_length_next  = rx_length_reg;
        rx_count_next   = rx_count_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        head_base_next  = head_base_reg;
        tail_base_next  = tail_base_reg;
        queued_next     = queued_reg;
        tx_pos_next     = tx_pos_reg;
        build_len_next  = build_len_reg;
        build_drop_next = build_drop_reg;
        attn_next       = attn_reg;
        slot_wr_en      = 1'b0;
        mem_wr_en       = 1'b0;
        mem_rd_en       = 1'b0;
        res             = '0;

        if (take)
        begin
            case (cmd_t'(cmd))
                CMD_EXCHANGE:
                begin
                    // Receive side framing
                    case (rx_state_reg)
                        RX_IDLE:
                        begin
                            if (data_byte == FRAME_START)
                            begin
                                rx_state_next = RX_LEN_HI;
                                rx_count_next = '0;
                            end
                        end
                        RX_LEN_HI:
                        begin
                            rx_length_next = {data_byte, 8'h00};
                            rx_state_next  = RX_LEN_LO;
                        end
                        RX_LEN_LO:
                        begin
                            rx_length_next = rx_len_new;
                            rx_count_next  = '0;
                            // empty frame ends after its header
                            rx_state_next  = (rx_len_new == 16'd0) ? RX_IDLE : RX_PAYLOAD;
                        end
                        RX_PAYLOAD:
                        begin
                            res.payload_valid = 1'b1;
                            res.payload_byte  = data_byte;
                            if (rx_count_inc == rx_length_reg)
                            begin
                                res.payload_last = 1'b1;
                                rx_state_next    = RX_IDLE;
                                rx_count_next    = '0;
                            end
                            else
                            begin
                                rx_count_next = rx_count_inc;
                            end
                        end
                        default:
                        begin
                            rx_state_next = RX_IDLE;
                        end
                    endcase

                    // Transmit side: header bytes here, payload from the store
                    if (queued_reg != '0)
                    begin
                        if (tx_pos_reg == POS_W'(0))
                        begin
                            res.tx_hdr = FRAME_START;
                        end
                        else if (tx_pos_reg == POS_W'(1))
                        begin
                            res.tx_hdr = cur_len16[15:8];
                        end
                        else if (tx_pos_reg == POS_W'(2))
                        begin
                            res.tx_hdr = cur_len16[7:0];
                        end
                        else
                        begin
                            res.tx_from_mem = 1'b1;
                            mem_rd_en       = 1'b1;
                        end

                        if (pos_inc >= len_end)
                        begin
                            tx_pos_next    = '0;
                            head_next      = (head_reg == SLOT_LAST) ? '0
                                                                     : head_reg + SLOT_W'(1);
                            head_base_next = (head_base_reg == BASE_LAST) ? '0
                                                                          : head_base_reg + BASE_STEP;
                            queued_next    = queued_reg - CNT_W'(1);
                            if (queued_reg == CNT_W'(1))
                            begin
                                attn_next = 1'b1;
                            end
                        end
                        else
                        begin
                            tx_pos_next = POS_W'(pos_inc);
                        end
                    end
                end
                CMD_APPEND:
                begin
                    // tail slot is the one on air when full
                    if (queue_full)
                    begin
                        build_drop_next = 1'b1;
                    end
                    else if (build_len_reg < LEN_W'(PAYLOAD_MAX))
                    begin
                        mem_wr_en      = 1'b1;
                        build_len_next = build_len_reg + LEN_W'(1);
                    end
                end
                CMD_COMMIT:
                begin
                    if (queue_full || build_drop_reg)
                    begin
                        res.push_status = 1'b1;
                    end
                    else
                    begin
                        slot_wr_en     = 1'b1;
                        tail_next      = (tail_reg == SLOT_LAST) ? '0 : tail_reg + SLOT_W'(1);
                        tail_base_next = (tail_base_reg == BASE_LAST) ? '0
                                                                      : tail_base_reg + BASE_STEP;
                        queued_next    = queued_reg + CNT_W'(1);
                        attn_next      = 1'b0;
                    end
                    build_len_next  = '0;
                    build_drop_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        res.irq_n = attn_next;
    end

    // Ring bookkeeping
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        queued_reg <= CNT_FULL)
        else $error("queued count above slot count");

    a_ring_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == tail_reg) == (queued_reg == '0 || queued_reg == CNT_FULL))
        else $error("head/tail pointers disagree with queued count");

    a_attn: assert property (@(posedge clk) disable iff (!rst_n)
        attn_reg == (queued_reg == '0))
        else $error("attention level disagrees with queued count");

    a_tx_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (tx_pos_reg != '0) |-> (queued_reg != '0))
        else $error("transmit position advanced with empty queue");

endmodule

@@ rtl/spi_slave_frame_queue.sv @@
// A request accepted by take is registered in stage 1, then moves on to the output register.
// One request per cycle while in_stall is low; each request makes at most one store access.
// Pending transmit payload is read from the registered store and merged at the output register.
// Reset (rst_n, async low) clears framing, ring pointers and the stage 1 and output valid flags.
// The frame store and slot lengths are not cleared; no entry is read before written.
module spi_slave_frame_queue
    import sfq_pkg::*;
#(
    parameter int SLOTS      = 8,
    parameter int SLOT_BYTES = 80
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] cmd,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] tx_byte,
    output logic       payload_valid,
    output logic [7:0] payload_byte,
    output logic       payload_last,
    output logic       irq_n,
    output logic       push_status
);

    localparam int DEPTH  = SLOTS * (SLOT_BYTES - 1);
    localparam int ADDR_W = $clog2(DEPTH);

    logic              take;
    logic              s1_move;
    logic              s1_valid_reg, s1_valid_next;
    logic              out_valid_reg, out_valid_next;
    step_res_t         s1_res_reg;
    step_res_t         res;

    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [7:0]        mem_wr_data;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [7:0]        mem_rd_data;

    logic [7:0]        tx_byte_reg;
    logic              payload_valid_reg;
    logic [7:0]        payload_byte_reg;
    logic              payload_last_reg;
    logic              irq_n_reg;
    logic              push_status_reg;

    sfq_ctrl #(
        .SLOTS      (SLOTS),
        .SLOT_BYTES (SLOT_BYTES),
        .ADDR_W     (ADDR_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .res         (res)
    );

    sfq_store_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Handshake: stage 1 waits on the store read, output register parts the sides
    assign s1_move  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_move;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_res_reg <= res;
        end
    end

    // Output register, store data merged here
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            tx_byte_reg       <= s1_res_reg.tx_from_mem ? mem_rd_data : s1_res_reg.tx_hdr;
            payload_valid_reg <= s1_res_reg.payload_valid;
            payload_byte_reg  <= s1_res_reg.payload_byte;
            payload_last_reg  <= s1_res_reg.payload_last;
            irq_n_reg         <= s1_res_reg.irq_n;
            push_status_reg   <= s1_res_reg.push_status;
        end
    end

    assign out_valid     = out_valid_reg;
    assign tx_byte       = tx_byte_reg;
    assign payload_valid = payload_valid_reg;
    assign payload_byte  = payload_byte_reg;
    assign payload_last  = payload_last_reg;
    assign irq_n         = irq_n_reg;
    assign push_status   = push_status_reg;

    a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> s1_valid_reg)
        else $error("accepted request not held in stage 1");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && out_stall) |=> s1_valid_reg)
        else $error("stage 1 request lost during output stall");

    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!payload_last_reg || payload_valid_reg))
        else $error("last mark without payload byte");

endmodule
